// ===== hw/rtl/sdgf_pkg.sv =====
package sdgf_pkg;

   localparam int unsigned NUM_DIGITS = 10;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned CHAR_W     = 7;
   localparam int unsigned CONV_STEPS = VALUE_W;
   localparam int unsigned CNT_W      = $clog2(CONV_STEPS);

   // Digit position of the thousands digit, and of the millions and billions digits.
   localparam logic [IDX_W-1:0] POS_THOUSANDS = IDX_W'(3);
   localparam logic [IDX_W-1:0] POS_MILLIONS  = IDX_W'(6);
   localparam logic [IDX_W-1:0] POS_BILLIONS  = IDX_W'(9);

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 7'h2C;
   localparam logic [2:0]        DIGIT_HIGH = 3'b011;

   localparam logic MODE_GROUPED = 1'b0;
   localparam logic MODE_VOLUME  = 1'b1;

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_type;

endpackage

// ===== hw/rtl/sdgf_dabble_step.sv =====
module sdgf_dabble_step (
   input  sdgf_pkg::bcd_type digits_in,
   input  logic              bin_msb,
   output sdgf_pkg::bcd_type digits_out
);
   import sdgf_pkg::*;

   bcd_type                           corrected;
   logic [NUM_DIGITS*DIGIT_W-1:0]     flat;

   // Each digit of five or more gets three added so that the shift carries correctly.
   always_comb begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (digits_in[k] >= DIGIT_W'(5)) begin
            corrected[k] = digits_in[k] + DIGIT_W'(3);
         end else begin
            corrected[k] = digits_in[k];
         end
      end
   end

   assign flat       = corrected;
   assign digits_out = {flat[NUM_DIGITS*DIGIT_W-2:0], bin_msb};

endmodule

// ===== hw/rtl/signed_decimal_grouped_formatter.sv =====
// Channel   Ports                                         Handshake
// input     req_value, req_format_mode                    start && !busy
// result    rsp_character, rsp_last_char                  rsp_valid, one-cycle strobe per beat
//
// An item is loaded, then goes through the shift-add-3 conversion (one bit of the 32-bit
// magnitude per cycle through the shared correction unit), a state that locates the
// leading digit, and then one character per cycle, 1 to 14 characters.
// A new item is accepted only once the previous one is finished; busy is high from
// the accepting edge until the last character has been issued.
// Reset is synchronous and active high; the receiver cannot stall, each beat shows once.
module signed_decimal_grouped_formatter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [sdgf_pkg::VALUE_W-1:0] req_value,
   input  logic                            req_format_mode,
   output logic                            rsp_valid,
   output logic [sdgf_pkg::CHAR_W-1:0]     rsp_character,
   output logic                            rsp_last_char
);
   import sdgf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CONV  = 6'b000010,
      ST_LEAD  = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_DIGIT = 6'b010000,
      ST_SEP   = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [VALUE_W-1:0]      bin_ff, bin_in;
   bcd_type                 bcd_ff, bcd_in;
   bcd_type                 bcd_step;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    neg_ff, neg_in;
   logic                    mode_ff, mode_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_character_ff, rsp_character_in;
   logic                    rsp_last_char_ff, rsp_last_char_in;

   logic [VALUE_W-1:0]      raw;
   logic [VALUE_W-1:0]      mag;
   logic [IDX_W-1:0]        lead;
   logic                    group_end;
   logic [DIGIT_W-1:0]      cur_digit;

   sdgf_dabble_step u_step (
      .digits_in  (bcd_ff),
      .bin_msb    (bin_ff[VALUE_W-1]),
      .digits_out (bcd_step)
   );

   assign raw = req_value;
   assign mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

   // Highest nonzero digit; volume mode always prints at least the thousands digit.
   always_comb begin
      lead = '0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (bcd_ff[k] != '0) begin
            lead = IDX_W'(k);
         end
      end
      if (mode_ff == MODE_VOLUME && lead < POS_THOUSANDS) begin
         lead = POS_THOUSANDS;
      end
   end

   assign cur_digit = bcd_ff[idx_ff];

   always_comb begin
      if (mode_ff == MODE_VOLUME) begin
         group_end = (idx_ff == POS_THOUSANDS);
      end else begin
         group_end = idx_ff inside {POS_THOUSANDS, POS_MILLIONS, POS_BILLIONS};
      end
   end

   always_comb begin
      state_in         = state_ff;
      bin_in           = bin_ff;
      bcd_in           = bcd_ff;
      cnt_in           = cnt_ff;
      idx_in           = idx_ff;
      neg_in           = neg_ff;
      mode_in          = mode_ff;
      rsp_valid_in     = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_char_in = rsp_last_char_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bin_in   = mag;
               bcd_in   = '0;
               cnt_in   = '0;
               neg_in   = raw[VALUE_W-1];
               mode_in  = req_format_mode;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = bcd_step;
            bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CONV_STEPS - 1)) begin
               state_in = ST_LEAD;
            end
         end
         ST_LEAD: begin
            idx_in   = lead;
            state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = CHAR_MINUS;
            rsp_last_char_in = 1'b0;
            state_in         = ST_DIGIT;
         end
         ST_DIGIT: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = {DIGIT_HIGH, cur_digit};
            rsp_last_char_in = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else if (group_end) begin
               state_in = ST_SEP;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_SEP: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = (mode_ff == MODE_VOLUME) ? CHAR_COMMA : CHAR_DOT;
            rsp_last_char_in = 1'b0;
            idx_in           = idx_ff - IDX_W'(1);
            state_in         = ST_DIGIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff           <= bin_in;
      bcd_ff           <= bcd_in;
      cnt_ff           <= cnt_in;
      idx_ff           <= idx_in;
      neg_ff           <= neg_in;
      mode_ff          <= mode_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_char_ff <= rsp_last_char_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last_char = rsp_last_char_ff;

endmodule
